>>> sv/tet_pkg.sv
// shared types, constants and helpers for the thermal edge transfer block
`default_nettype none

package tet_pkg;

  // field widths
  localparam int TempW  = 16;
  localparam int CondW  = 16;
  localparam int HeatW  = 16;
  localparam int MassW  = 8;
  localparam int ThrW   = 16;
  localparam int ScaleW = 15;
  localparam int CfgW   = 16;
  localparam int XferW  = 32;

  // heat times mass product and the divide-by-255 reciprocal
  localparam int HmW     = HeatW + MassW;
  localparam int RecipW  = 17;
  localparam logic [RecipW-1:0] Recip255 = 17'd65793;
  localparam int RecipShift = 24;
  localparam logic [7:0] MassFull = 8'd255;

  // equilibrium divider geometry
  localparam int QuotW      = 32;
  localparam int DenW       = HeatW + 1;
  localparam int NumW       = TempW + 2 * HeatW;
  localparam int DivStages  = 8;
  localparam int StepsPerStage = QuotW / DivStages;

  // rate path
  localparam int RateProdW = 2 * TempW + CondW + ScaleW;
  localparam int RateShift = 16;
  localparam int MagW      = XferW - 1;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_ACTIVATION_THRESHOLD = 1'b0,
    REG_STEP_SCALE           = 1'b1
  } reg_index_t;

  // per-item flags that ride alongside the divider
  typedef struct packed {
    logic             positive;
    logic             active;
    logic [MagW-1:0]  rate;
  } side_t;

  // partial remainder and shifting numerator/quotient word
  typedef struct packed {
    logic [DenW-1:0]  rem;
    logic [QuotW-1:0] nq;
  } div_acc_t;

  // one restoring division step
  function automatic div_acc_t div_step(input div_acc_t a, input logic [DenW-1:0] d);
    logic [DenW:0] t;
    logic          take;
    div_acc_t      r;
    t    = {a.rem, a.nq[QuotW-1]};
    take = (t >= {1'b0, d});
    r.rem = take ? DenW'(t - {1'b0, d}) : t[DenW-1:0];
    r.nq  = {a.nq[QuotW-2:0], take};
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/tet_in_if.sv
// input channel carrying both cells of one edge
`default_nettype none

interface tet_in_if;
  import tet_pkg::*;

  logic              valid;
  logic              ready;
  logic [TempW-1:0]  temp_first;
  logic [TempW-1:0]  temp_second;
  logic [CondW-1:0]  cond_first;
  logic [CondW-1:0]  cond_second;
  logic [HeatW-1:0]  heat_first;
  logic [HeatW-1:0]  heat_second;
  logic [MassW-1:0]  mass_first;
  logic [MassW-1:0]  mass_second;
  logic              weighted_first;
  logic              weighted_second;

  modport source (
    output valid, temp_first, temp_second, cond_first, cond_second,
           heat_first, heat_second, mass_first, mass_second,
           weighted_first, weighted_second,
    input  ready
  );

  modport sink (
    input  valid, temp_first, temp_second, cond_first, cond_second,
           heat_first, heat_second, mass_first, mass_second,
           weighted_first, weighted_second,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/tet_out_if.sv
// output channel carrying the signed transfer of one edge
`default_nettype none

interface tet_out_if;
  import tet_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [XferW-1:0] transfer;

  modport source (
    output valid, transfer,
    input  ready
  );

  modport sink (
    input  valid, transfer,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/thermal_edge_transfer.sv
// thermal edge transfer: top level with capacity, product and output stages
// Usage: each item on in_ch holds two neighboring cells (temperature,
// conductivity, specific heat, mass byte, mass-weighting flag); out_ch returns
// one signed transfer per item, in order, positive when heat moves from the
// first cell to the second.
// Both channels use valid/ready; an item moves when both are high.
// Configuration: cfg_write with cfg_index selects activation_threshold (0)
// or the step scale (1); cfg_data is taken at the same edge. Write only while
// the pipeline is empty.
// Pipeline: the item passes five stages for gap, capacity and products, eight
// divider stages for the equilibrium term (four quotient bits each), and the
// output register, the first of them loaded at the accepting edge.
// Throughput: one item per cycle while out_ch.ready stays high; every stage is
// pipelined and no unit is shared between items.
// Reset: rst is synchronous; it empties the pipeline and restores the
// threshold to 2 and the cadence scale to 1.
// Stall: when out_ch.ready is low, the held result stays put while empty
// stages further back keep filling; in_ch.ready drops only once every stage
// holds an item. Nothing is dropped or repeated.
`default_nettype none

module thermal_edge_transfer import tet_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire reg_index_t       cfg_index,
  input  wire logic [CfgW-1:0]  cfg_data,
  tet_in_if.sink                in_ch,
  tet_out_if.source             out_ch
);

  // configuration registers
  logic [ThrW-1:0]   act_thr;
  logic [ScaleW-1:0] cad_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_thr   <= ThrW'(2);
      cad_scale <= ScaleW'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACTIVATION_THRESHOLD: act_thr   <= cfg_data[ThrW-1:0];
        REG_STEP_SCALE:           cad_scale <= cfg_data[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and advance enables
  logic v1, v2, v3, v4, v5, vo;
  logic en1, en2, en3, en4, en5, en_o;
  logic div_in_ready, div_out_valid;

  assign en_o = !vo || out_ch.ready;
  assign en5  = !v5 || div_in_ready;
  assign en4  = !v4 || en5;
  assign en3  = !v3 || en4;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_ch.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // stage 1: gap, direction, activity, heat-mass products
  logic [TempW-1:0] gap_c;
  logic             pos_c;
  logic [CondW-1:0] kmin_c;

  assign pos_c  = in_ch.temp_first > in_ch.temp_second;
  assign gap_c  = pos_c ? in_ch.temp_first - in_ch.temp_second
                        : in_ch.temp_second - in_ch.temp_first;
  assign kmin_c = (in_ch.cond_first < in_ch.cond_second) ? in_ch.cond_first
                                                         : in_ch.cond_second;

  logic [TempW-1:0] s1_gap;
  logic             s1_pos, s1_act;
  logic [CondW-1:0] s1_k;
  logic [HmW-1:0]   s1_hm_a, s1_hm_b;
  logic [HeatW-1:0] s1_heat_a, s1_heat_b;
  logic             s1_w_a, s1_w_b, s1_nz_a, s1_nz_b;

  always_ff @(posedge clk) begin
    if (en1 && in_ch.valid) begin
      s1_gap    <= gap_c;
      s1_pos    <= pos_c;
      s1_act    <= (gap_c >= act_thr) && (kmin_c != '0);
      s1_k      <= kmin_c;
      s1_hm_a   <= HmW'(in_ch.heat_first) * HmW'(in_ch.mass_first);
      s1_hm_b   <= HmW'(in_ch.heat_second) * HmW'(in_ch.mass_second);
      s1_heat_a <= in_ch.heat_first;
      s1_heat_b <= in_ch.heat_second;
      s1_w_a    <= in_ch.weighted_first;
      s1_w_b    <= in_ch.weighted_second;
      s1_nz_a   <= in_ch.cond_first != '0;
      s1_nz_b   <= in_ch.cond_second != '0;
    end
  end

  // stage 2: divide by 255 estimate through the reciprocal
  logic [HmW+RecipW-1:0] rp_a, rp_b;
  assign rp_a = (HmW+RecipW)'(s1_hm_a) * (HmW+RecipW)'(Recip255);
  assign rp_b = (HmW+RecipW)'(s1_hm_b) * (HmW+RecipW)'(Recip255);

  logic [TempW-1:0]  s2_gap;
  logic              s2_pos, s2_act;
  logic [CondW-1:0]  s2_k;
  logic [HmW-1:0]    s2_hm_a, s2_hm_b;
  logic [RecipW-1:0] s2_est_a, s2_est_b;
  logic [HeatW-1:0]  s2_heat_a, s2_heat_b;
  logic              s2_w_a, s2_w_b, s2_nz_a, s2_nz_b;

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2_gap    <= s1_gap;
      s2_pos    <= s1_pos;
      s2_act    <= s1_act;
      s2_k      <= s1_k;
      s2_hm_a   <= s1_hm_a;
      s2_hm_b   <= s1_hm_b;
      s2_est_a  <= rp_a[RecipShift +: RecipW];
      s2_est_b  <= rp_b[RecipShift +: RecipW];
      s2_heat_a <= s1_heat_a;
      s2_heat_b <= s1_heat_b;
      s2_w_a    <= s1_w_a;
      s2_w_b    <= s1_w_b;
      s2_nz_a   <= s1_nz_a;
      s2_nz_b   <= s1_nz_b;
    end
  end

  // stage 3: quotient correction and capacity selection
  function automatic logic [HeatW-1:0] capacity(
    input logic [HmW-1:0]    hm,
    input logic [RecipW-1:0] est,
    input logic [HeatW-1:0]  heat,
    input logic              weighted,
    input logic              cond_nz
  );
    logic [HmW:0]       prod;
    logic [HmW:0]       rem;
    logic [RecipW-1:0]  q;
    logic [HeatW-1:0]   c;
    prod = {est, 8'b0} - (HmW+1)'(est);
    rem  = {1'b0, hm} - prod;
    q    = (rem >= (HmW+1)'(MassFull)) ? est + RecipW'(1) : est;
    c    = weighted ? q[HeatW-1:0] : heat;
    if (!cond_nz || c == '0) begin
      c = HeatW'(1);
    end
    return c;
  endfunction

  logic [TempW-1:0] s3_gap;
  logic             s3_pos, s3_act;
  logic [CondW-1:0] s3_k;
  logic [HeatW-1:0] s3_ca, s3_cb;

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      s3_gap <= s2_gap;
      s3_pos <= s2_pos;
      s3_act <= s2_act;
      s3_k   <= s2_k;
      s3_ca  <= capacity(s2_hm_a, s2_est_a, s2_heat_a, s2_w_a, s2_nz_a);
      s3_cb  <= capacity(s2_hm_b, s2_est_b, s2_heat_b, s2_w_b, s2_nz_b);
    end
  end

  // stage 4: first-level products and capacity sum
  logic [HeatW-1:0] cmin_c;
  assign cmin_c = (s3_ca < s3_cb) ? s3_ca : s3_cb;

  logic                      s4_pos, s4_act;
  logic [TempW+HeatW-1:0]    s4_gca, s4_gcm;
  logic [CondW+ScaleW-1:0]   s4_ks;
  logic [HeatW-1:0]          s4_cb;
  logic [DenW-1:0]           s4_sum;

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      s4_pos <= s3_pos;
      s4_act <= s3_act;
      s4_gca <= (TempW+HeatW)'(s3_gap) * (TempW+HeatW)'(s3_ca);
      s4_gcm <= (TempW+HeatW)'(s3_gap) * (TempW+HeatW)'(cmin_c);
      s4_ks  <= (CondW+ScaleW)'(s3_k) * (CondW+ScaleW)'(cad_scale);
      s4_cb  <= s3_cb;
      s4_sum <= DenW'(s3_ca) + DenW'(s3_cb);
    end
  end

  // stage 5: equilibrium numerator and rate product
  logic                 s5_pos, s5_act;
  logic [NumW-1:0]      s5_num;
  logic [RateProdW-1:0] s5_rt;
  logic [DenW-1:0]      s5_sum;

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      s5_pos <= s4_pos;
      s5_act <= s4_act;
      s5_num <= NumW'(s4_gca) * NumW'(s4_cb);
      s5_rt  <= RateProdW'(s4_gcm) * RateProdW'(s4_ks);
      s5_sum <= s4_sum;
    end
  end

  // rate scaled down, clipped to the magnitude range, at least one
  localparam int RateW = RateProdW - RateShift;
  logic [RateW-1:0] rate_full;
  logic [MagW-1:0]  rate_clip;
  side_t            side_c;

  assign rate_full = s5_rt[RateProdW-1:RateShift];
  always_comb begin
    if (rate_full[RateW-1:MagW] != '0) begin
      rate_clip = '1;
    end else if (rate_full[MagW-1:0] == '0) begin
      rate_clip = MagW'(1);
    end else begin
      rate_clip = rate_full[MagW-1:0];
    end
    side_c.positive = s5_pos;
    side_c.active   = s5_act;
    side_c.rate     = rate_clip;
  end

  // equilibrium divide
  logic [QuotW-1:0] quot;
  side_t            div_side;

  tet_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_ready  (div_in_ready),
    .num       (s5_num),
    .den       (s5_sum),
    .in_side   (side_c),
    .out_valid (div_out_valid),
    .out_ready (en_o),
    .quot      (quot),
    .out_side  (div_side)
  );

  // output stage: half equilibrium against rate (zero when inactive), then sign
  logic [MagW-1:0]         half_eq, mag_c;
  logic signed [XferW-1:0] xfer;

  assign half_eq = quot[QuotW-1:1];
  always_comb begin
    if (!div_side.active) begin
      mag_c = '0;
    end else if (div_side.rate < half_eq) begin
      mag_c = div_side.rate;
    end else begin
      mag_c = half_eq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en_o) begin
      vo <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && div_out_valid) begin
      xfer <= div_side.positive ? $signed({1'b0, mag_c}) : -$signed({1'b0, mag_c});
    end
  end

  assign out_ch.valid    = vo;
  assign out_ch.transfer = xfer;

endmodule

`default_nettype wire

>>> sv/tet_divider.sv
// pipelined restoring divider for the equilibrium term, four quotient bits per stage
`default_nettype none

module tet_divider import tet_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [NumW-1:0]  num,
  input  wire logic [DenW-1:0]  den,
  input  wire side_t            in_side,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [QuotW-1:0]      quot,
  output side_t                 out_side
);

  logic [DivStages-1:0] v;
  logic [DivStages-1:0] en;
  div_acc_t             acc   [DivStages];
  logic [DenW-1:0]      den_q [DivStages];
  side_t                side_q[DivStages];

  // stage advances when empty or when the next one moves
  always_comb begin
    en[DivStages-1] = !v[DivStages-1] || out_ready;
    for (int s = DivStages - 2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign in_ready = en[0];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    div_acc_t        start;
    div_acc_t        work;
    logic [DenW-1:0] d;
    side_t           sd;
    logic            vin;

    // stage inputs: first stage starts from the high numerator bits
    if (s == 0) begin : g_first
      always_comb begin
        start.rem = DenW'(num[NumW-1:QuotW]);
        start.nq  = num[QuotW-1:0];
        d         = den;
        sd        = in_side;
        vin       = in_valid;
      end
    end else begin : g_next
      always_comb begin
        start = acc[s-1];
        d     = den_q[s-1];
        sd    = side_q[s-1];
        vin   = v[s-1];
      end
    end

    // four dependent subtract steps
    always_comb begin
      work = start;
      for (int i = 0; i < StepsPerStage; i++) begin
        work = div_step(work, d);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en[s]) begin
        v[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s] && vin) begin
        acc[s]    <= work;
        den_q[s]  <= d;
        side_q[s] <= sd;
      end
    end
  end

  assign out_valid = v[DivStages-1];
  assign quot      = acc[DivStages-1].nq;
  assign out_side  = side_q[DivStages-1];

endmodule

`default_nettype wire
